// File: rtl/cbm_pkg.sv
// Shared types, codes and a helper function of the cartridge bank mirror mapper.
package cbm_pkg;

  // Request kinds carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_CPU_READ  = 2'd1,
    REQ_PPU_FETCH = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_type_e;

  // Mirroring codes returned in mirror_mode.
  typedef enum logic [1:0] {
    MIR_HORIZONTAL = 2'd0,
    MIR_VERTICAL   = 2'd1,
    MIR_SINGLE_LO  = 2'd2,
    MIR_SINGLE_HI  = 2'd3
  } mirror_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VARIANT   = 2'd0,
    CFG_FIXED_TOP = 2'd1
  } cfg_index_e;

  localparam int unsigned PatRegs = 6;
  localparam int unsigned PrgRegs = 3;

  // Register window addresses, upper 13 bits of the address.
  localparam logic [12:0] PatWindowHi = 13'h0FDE;  // 0x7EF0..0x7EF7
  localparam logic [12:0] PrgWindowHi = 13'h0FDF;  // 0x7EF8..0x7EFF
  localparam logic [15:0] MirrorAddr  = 16'h7EF6;
  localparam logic [7:0]  FixedTopRst = 8'hFF;

  // One bus access request.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  // One translation result.
  typedef struct packed {
    logic        bank_valid;
    logic [7:0]  bank_number;
    logic [1:0]  mirror_mode;
  } rsp_t;

  // Bank state seen by the translation logic.
  typedef struct packed {
    logic [PatRegs-1:0][7:0] pat;
    logic [PrgRegs-1:0][7:0] prg;
    logic [7:0]              fixed_top;
  } bank_state_t;

  // Pattern register that covers a 1KB slot: slots 0-3 share 2KB registers.
  function automatic logic [2:0] slot_reg_idx(input logic [2:0] slot);
    logic [2:0] idx;
    if (slot[2]) begin
      idx = slot - 3'd2;
    end else begin
      idx = {2'b00, slot[1]};
    end
    return idx;
  endfunction

endpackage

// File: rtl/cbm_state.sv
// Bank, mirroring and configuration registers of the mapper, with their update logic.
module cbm_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                upd_en_i,
  input  cbm_pkg::req_t       req_i,
  output cbm_pkg::bank_state_t state_o,
  output logic [1:0]          mirror_d_o
);

  logic [cbm_pkg::PatRegs-1:0][7:0] pat_q, pat_d;
  logic [cbm_pkg::PrgRegs-1:0][7:0] prg_q, prg_d;
  logic       mcb_q, mcb_d;
  logic [2:0] last_slot_q, last_slot_d;
  logic       ssp_q, ssp_d;
  logic       variant_q;
  logic [7:0] fixed_top_q;

  logic       is_write, is_fetch;
  logic       pat_hit, mir_hit, prg_hit;
  logic [2:0] fetch_slot;
  logic [1:0] prg_idx;

  // Decode the register window and fetch range.
  always_comb begin
    is_write   = upd_en_i && (req_i.req_type == cbm_pkg::REQ_CPU_WRITE);
    is_fetch   = upd_en_i && (req_i.req_type == cbm_pkg::REQ_PPU_FETCH) &&
                 !req_i.address[13];
    pat_hit    = is_write && (req_i.address[15:3] == cbm_pkg::PatWindowHi) &&
                 (req_i.address[2:0] <= 3'd5);
    mir_hit    = is_write && (req_i.address == cbm_pkg::MirrorAddr);
    prg_hit    = is_write && (req_i.address[15:3] == cbm_pkg::PrgWindowHi) &&
                 (req_i.address[2:1] != 2'b00);
    prg_idx    = req_i.address[2:1] - 2'd1;
    fetch_slot = req_i.address[12:10];
  end

  // Next values of the bank and mirroring state.
  always_comb begin
    pat_d       = pat_q;
    prg_d       = prg_q;
    mcb_d       = mcb_q;
    last_slot_d = last_slot_q;
    ssp_d       = ssp_q;
    if (pat_hit) begin
      pat_d[req_i.address[2:0]] = req_i.write_data;
    end
    if (mir_hit) begin
      mcb_d = req_i.write_data[0];
    end
    if (prg_hit) begin
      prg_d[prg_idx] = req_i.write_data;
    end
    // In variant 1, pattern and mirroring writes re-evaluate the single-screen page.
    if (variant_q && (pat_hit || mir_hit)) begin
      ssp_d = pat_d[cbm_pkg::slot_reg_idx(last_slot_q)][7];
    end
    // A pattern fetch moves the tracked slot in variant 1.
    if (variant_q && is_fetch) begin
      last_slot_d = fetch_slot;
      ssp_d       = pat_q[cbm_pkg::slot_reg_idx(fetch_slot)][7];
    end
  end

  // Mirroring in force after this request.
  always_comb begin
    if (variant_q) begin
      mirror_d_o = ssp_d ? cbm_pkg::MIR_SINGLE_HI : cbm_pkg::MIR_SINGLE_LO;
    end else begin
      mirror_d_o = mcb_d ? cbm_pkg::MIR_VERTICAL : cbm_pkg::MIR_HORIZONTAL;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q       <= '0;
      prg_q       <= '0;
      mcb_q       <= 1'b0;
      last_slot_q <= 3'd0;
      ssp_q       <= 1'b0;
    end else if (upd_en_i) begin
      pat_q       <= pat_d;
      prg_q       <= prg_d;
      mcb_q       <= mcb_d;
      last_slot_q <= last_slot_d;
      ssp_q       <= ssp_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q   <= 1'b0;
      fixed_top_q <= cbm_pkg::FixedTopRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cbm_pkg::CFG_VARIANT:   variant_q   <= cfg_data_i[0];
        cbm_pkg::CFG_FIXED_TOP: fixed_top_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign state_o.pat       = pat_q;
  assign state_o.prg       = prg_q;
  assign state_o.fixed_top = fixed_top_q;

endmodule

// File: rtl/cbm_xlate.sv
// Address to bank translation for CPU and PPU requests.
module cbm_xlate (
  input  cbm_pkg::req_t        req_i,
  input  cbm_pkg::bank_state_t state_i,
  output logic                 bank_valid_o,
  output logic [7:0]           bank_number_o
);

  logic [2:0] slot;
  logic [7:0] pat_reg;

  always_comb begin
    slot          = req_i.address[12:10];
    pat_reg       = state_i.pat[cbm_pkg::slot_reg_idx(slot)];
    bank_valid_o  = 1'b0;
    bank_number_o = 8'd0;
    case (req_i.req_type)
      cbm_pkg::REQ_CPU_WRITE, cbm_pkg::REQ_CPU_READ: begin
        // 8KB program windows; the top one is fixed.
        if (req_i.address[15:13] == 3'b111) begin
          bank_valid_o  = 1'b1;
          bank_number_o = state_i.fixed_top;
        end else if (req_i.address[15]) begin
          bank_valid_o  = 1'b1;
          bank_number_o = state_i.prg[req_i.address[14:13]];
        end
      end
      cbm_pkg::REQ_PPU_FETCH: begin
        // Pattern space below 0x2000; 2KB registers pick an even 1KB pair.
        if (!req_i.address[13]) begin
          bank_valid_o = 1'b1;
          if (slot[2]) begin
            bank_number_o = pat_reg;
          end else begin
            bank_number_o = {1'b0, pat_reg[6:1], slot[0]};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/cartridge_bank_mirror_mapper_core.sv
// Top level of the cartridge bank mirror mapper: request and result stages.
//
// Usage: each request on req_i is one bus access (CPU write, CPU read
// translate or PPU pattern fetch). It is taken when req_valid_i and
// req_ready_o are both high. One result per request appears on rsp_o with
// rsp_valid_o, and is taken when rsp_ready_i is high.
// The result becomes valid once the request, registered at acceptance in the
// request stage, is translated and its state update applied while it moves
// into the result register. Throughput is one request per cycle while the
// receiver does not stall; the stage pair is a two-deep pipeline that advances
// whenever the result register is empty or being drained.
// When the receiver stalls, the result holds, the request stage fills, and
// req_ready_o falls until the result is taken.
// Configuration writes on cfg_valid_i/cfg_index_i/cfg_data_i are always
// taken (cfg_ready_o is high) and are meant for idle periods.
// Reset clears the pipeline, all bank registers, the mirroring state, sets
// variant 0 and the fixed top program bank to 255.
module cartridge_bank_mirror_mapper_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cbm_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cbm_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  logic                 in_vld_q;
  cbm_pkg::req_t        in_req_q;
  logic                 out_vld_q;
  cbm_pkg::rsp_t        out_rsp_q, out_rsp_d;
  logic                 out_free, advance;
  cbm_pkg::bank_state_t state;
  logic [1:0]           mirror_d;
  logic                 bank_valid;
  logic [7:0]           bank_number;

  // Pipeline flow control.
  assign out_free    = !out_vld_q || rsp_ready_i;
  assign advance     = in_vld_q && out_free;
  assign req_ready_o = !in_vld_q || out_free;
  assign cfg_ready_o = 1'b1;

  cbm_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_en_i    (advance),
    .req_i       (in_req_q),
    .state_o     (state),
    .mirror_d_o  (mirror_d)
  );

  cbm_xlate u_xlate (
    .req_i         (in_req_q),
    .state_i       (state),
    .bank_valid_o  (bank_valid),
    .bank_number_o (bank_number)
  );

  // Result assembled from the translation and the updated mirroring.
  always_comb begin
    out_rsp_d.bank_valid  = bank_valid;
    out_rsp_d.bank_number = bank_number;
    out_rsp_d.mirror_mode = mirror_d;
  end

  // Request stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_ready_o) begin
      in_vld_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      in_req_q <= req_i;
    end
  end

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_rsp_q;

endmodule

// File: rtl/cbm_checker.sv
// Port-level checks for the mapper core, bound to the top level.
module cbm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_ready_o,
  input logic          rsp_valid_o,
  input logic          rsp_ready_i,
  input cbm_pkg::rsp_t rsp_o
);

  // Reset empties the result register at once.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_o)
    else $error("result valid during reset");

  // A stalled result holds its value.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled result changed");

  // Outside a banked window the bank number reads zero.
  a_bank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.bank_valid |-> rsp_o.bank_number == 8'd0)
    else $error("bank number set outside a window");

  // With an empty result register the block always takes a request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_o |-> req_ready_o)
    else $error("request refused with empty result register");

  // A valid result carries no unknown bits.
  a_rsp_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !$isunknown(rsp_o))
    else $error("unknown bits in result");

endmodule

bind cartridge_bank_mirror_mapper_core cbm_checker u_cbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

// File: test/tb_top.sv
// Self-checking testbench for the cartridge bank mirror mapper core.
module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;

  // Mapper register window and translation boundaries.
  localparam logic [15:0] ChrRegFirst = 16'h7EF0;
  localparam logic [15:0] ChrRegLast  = 16'h7EF5;
  localparam logic [15:0] PrgRegFirst = 16'h7EFA;
  localparam logic [15:0] PrgRegLast  = 16'h7EFF;
  localparam logic [15:0] PrgWindow   = 16'h8000;
  localparam logic [15:0] FixedWindow = 16'hE000;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b1;
  logic          req_valid   = 1'b0;
  cbm_pkg::req_t req         = '0;
  logic          rsp_ready   = 1'b0;
  logic          cfg_valid   = 1'b0;
  logic [1:0]    cfg_index   = '0;
  logic [7:0]    cfg_data    = '0;
  logic          req_ready;
  logic          rsp_valid;
  cbm_pkg::rsp_t rsp;
  logic          cfg_ready;

  int unsigned send_idle_pct = 20;
  int unsigned rcv_idle_pct  = 20;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Mirror of the mapper state, updated as requests are accepted.
  logic [7:0] chr_bank [6];
  logic [7:0] prg_bank [3];
  logic       mirror_bit;
  logic [2:0] last_slot;
  logic       page;
  logic       variant_q;
  logic [7:0] fixed_top_q;

  cbm_pkg::rsp_t pending_rsp_q [$];

  cartridge_bank_mirror_mapper_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at random with the current percentage.
  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Pattern register covering a 1KB slot; slots 0-3 pair up on 2KB registers.
  function automatic logic [2:0] pattern_reg_of(input logic [2:0] slot);
    return slot[2] ? slot - 3'd2 : {2'b00, slot[1]};
  endfunction

  // In single-screen mode the page follows bit 7 of the last fetched slot's bank.
  function automatic void refresh_page();
    if (variant_q) page = chr_bank[pattern_reg_of(last_slot)][7];
  endfunction

  // Applies one request to the state mirror and returns the expected result.
  function automatic cbm_pkg::rsp_t mapper_translate(input cbm_pkg::req_t r);
    cbm_pkg::rsp_t res;
    logic [2:0]    slot;
    logic [7:0]    reg_val;
    res = '0;
    if (r.req_type == cbm_pkg::REQ_CPU_WRITE) begin
      if (r.address >= ChrRegFirst && r.address <= ChrRegLast) begin
        chr_bank[r.address[2:0]] = r.write_data;
        refresh_page();
      end else if (r.address == cbm_pkg::MirrorAddr) begin
        mirror_bit = r.write_data[0];
        refresh_page();
      end else if (r.address >= PrgRegFirst && r.address <= PrgRegLast) begin
        prg_bank[2'((r.address - PrgRegFirst) >> 1)] = r.write_data;
      end
    end
    if (r.req_type == cbm_pkg::REQ_CPU_WRITE || r.req_type == cbm_pkg::REQ_CPU_READ) begin
      if (r.address >= FixedWindow) begin
        res.bank_valid  = 1'b1;
        res.bank_number = fixed_top_q;
      end else if (r.address >= PrgWindow) begin
        res.bank_valid  = 1'b1;
        res.bank_number = prg_bank[r.address[14:13]];
      end
    end else if (r.req_type == cbm_pkg::REQ_PPU_FETCH && !r.address[13]) begin
      slot    = r.address[12:10];
      reg_val = chr_bank[pattern_reg_of(slot)];
      res.bank_valid  = 1'b1;
      res.bank_number = slot[2] ? reg_val : {1'b0, reg_val[6:1], slot[0]};
      if (variant_q) begin
        last_slot = slot;
        page      = reg_val[7];
      end
    end
    if (variant_q) begin
      res.mirror_mode = page ? cbm_pkg::MIR_SINGLE_HI : cbm_pkg::MIR_SINGLE_LO;
    end else begin
      res.mirror_mode = mirror_bit ? cbm_pkg::MIR_VERTICAL : cbm_pkg::MIR_HORIZONTAL;
    end
    return res;
  endfunction

  // Checks each result against the oldest expectation, then records new
  // requests and configuration writes accepted at this edge.
  always @(posedge clk_i) begin : result_check
    cbm_pkg::rsp_t want;
    if (!rst_ni) begin
      foreach (chr_bank[i]) chr_bank[i] = '0;
      foreach (prg_bank[i]) prg_bank[i] = '0;
      mirror_bit  = 1'b0;
      last_slot   = '0;
      page        = 1'b0;
      variant_q   = 1'b0;
      fixed_top_q = cbm_pkg::FixedTopRst;
      pending_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result with no request pending: %p", rsp);
          fail_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.bank_valid !== want.bank_valid) begin
            $error("bank_valid: expected %0d, got %0d", want.bank_valid, rsp.bank_valid);
            fail_count++;
          end
          if (rsp.bank_number !== want.bank_number) begin
            $error("bank_number: expected %0d, got %0d", want.bank_number,
                   rsp.bank_number);
            fail_count++;
          end
          if (rsp.mirror_mode !== want.mirror_mode) begin
            $error("mirror_mode: expected %0d, got %0d", want.mirror_mode,
                   rsp.mirror_mode);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) pending_rsp_q.push_back(mapper_translate(req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbm_pkg::CFG_VARIANT:   variant_q   = cfg_data[0];
          cbm_pkg::CFG_FIXED_TOP: fixed_top_q = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Sends one request, idling first at random; valid stays high afterwards.
  task automatic send_access(input cbm_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk_i); while (!req_ready);
  endtask

  task automatic access(input cbm_pkg::req_type_e kind, input logic [15:0] addr,
                        input logic [7:0] data);
    cbm_pkg::req_t r;
    r.req_type   = kind;
    r.address    = addr;
    r.write_data = data;
    send_access(r);
  endtask

  // Holds off the sender until every expected result has come back.
  task automatic wait_quiet();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input cbm_pkg::cfg_index_e idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly register window writes, banked reads and pattern fetches.
  function automatic cbm_pkg::req_t random_access();
    cbm_pkg::req_t r;
    int unsigned   pick;
    r.req_type   = 2'($urandom_range(3));
    r.address    = 16'($urandom);
    r.write_data = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.req_type = cbm_pkg::REQ_CPU_WRITE;
      r.address  = 16'(ChrRegFirst + $urandom_range(15));
    end else if (pick < 40) begin
      r.req_type = cbm_pkg::REQ_CPU_WRITE;
    end else if (pick < 60) begin
      r.req_type = cbm_pkg::REQ_CPU_READ;
      if ($urandom_range(3) != 0) r.address[15] = 1'b1;
    end else if (pick < 90) begin
      r.req_type = cbm_pkg::REQ_PPU_FETCH;
      if ($urandom_range(4) != 0) r.address[13] = 1'b0;
    end else if (pick < 95) begin
      r.req_type = cbm_pkg::REQ_UNUSED;
    end
    return r;
  endfunction

  // Program windows and out-of-window reads straight after reset.
  task automatic test_cpu_windows();
    access(cbm_pkg::REQ_CPU_READ, 16'h0000, 8'h00);
    access(cbm_pkg::REQ_CPU_READ, 16'h7FFF, 8'hFF);
    access(cbm_pkg::REQ_CPU_READ, 16'h8000, 8'h00);
    access(cbm_pkg::REQ_CPU_READ, 16'hDFFF, 8'h00);
    access(cbm_pkg::REQ_CPU_READ, 16'hE000, 8'h00);
    access(cbm_pkg::REQ_CPU_READ, 16'hFFFF, 8'h00);
    access(cbm_pkg::REQ_UNUSED,   16'hFFFF, 8'hFF);
  endtask

  // Writes across the register window, a write outside it, then pattern fetches.
  task automatic test_register_writes();
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EF0, 8'hFF);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EF5, 8'h80);
    access(cbm_pkg::REQ_CPU_WRITE, cbm_pkg::MirrorAddr, 8'hFF);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EF7, 8'h55);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EFB, 8'h81);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EFC, 8'h7E);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EFF, 8'hFF);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h8000, 8'h55);
    access(cbm_pkg::REQ_PPU_FETCH, 16'h0000, 8'h00);
    access(cbm_pkg::REQ_PPU_FETCH, 16'h07FF, 8'h00);
    access(cbm_pkg::REQ_PPU_FETCH, 16'h1FFF, 8'h00);
    access(cbm_pkg::REQ_PPU_FETCH, 16'h2000, 8'h00);
    access(cbm_pkg::REQ_PPU_FETCH, 16'hFFFF, 8'h00);
    // Bits 15:14 are dropped, so this lands in slot 1.
    access(cbm_pkg::REQ_PPU_FETCH, 16'hC400, 8'hFF);
  endtask

  task automatic test_fixed_top_bank();
    wait_quiet();
    write_config(cbm_pkg::CFG_FIXED_TOP, 8'h00);
    access(cbm_pkg::REQ_CPU_READ, 16'hFFFF, 8'h00);
    wait_quiet();
    write_config(cbm_pkg::CFG_FIXED_TOP, 8'hFF);
  endtask

  // The page tracks the last fetched slot; pattern and mirror writes re-evaluate it.
  task automatic test_single_screen();
    wait_quiet();
    write_config(cbm_pkg::CFG_VARIANT, 8'h01);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EF2, 8'h80);
    access(cbm_pkg::REQ_PPU_FETCH, 16'h0800, 8'h00);
    access(cbm_pkg::REQ_CPU_WRITE, 16'h7EF1, 8'h80);
    access(cbm_pkg::REQ_CPU_WRITE, cbm_pkg::MirrorAddr, 8'h00);
  endtask

  task automatic test_random_traffic(input int unsigned sender_gap,
                                     input int unsigned receiver_gap,
                                     input int unsigned count);
    send_idle_pct = sender_gap;
    rcv_idle_pct  = receiver_gap;
    repeat (count) begin
      // Now and then let the pipeline empty, sometimes flipping the variant.
      if ($urandom_range(49) == 0) begin
        wait_quiet();
        if ($urandom_range(1) != 0) begin
          write_config(cbm_pkg::CFG_VARIANT, 8'($urandom_range(1)));
        end
      end
      send_access(random_access());
    end
    wait_quiet();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cpu_windows();
    test_register_writes();
    test_fixed_top_bank();
    test_single_screen();

    wait_quiet();
    write_config(cbm_pkg::CFG_FIXED_TOP, 8'h00);
    test_random_traffic(30, 70, 200);
    write_config(cbm_pkg::CFG_VARIANT, 8'h00);
    write_config(cbm_pkg::CFG_FIXED_TOP, 8'hFF);
    test_random_traffic(70, 30, 200);
    write_config(cbm_pkg::CFG_VARIANT, 8'h01);
    write_config(cbm_pkg::CFG_FIXED_TOP, 8'($urandom));
    test_random_traffic(0, 0, 200);

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_rsp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cbm_pkg.sv
rtl/cbm_state.sv
rtl/cbm_xlate.sv
rtl/cartridge_bank_mirror_mapper_core.sv
rtl/cbm_checker.sv
test/tb_top.sv
